// File: design/tlpw_pkg.sv
// Shared types, constants and the entry check of the two-level page walker.
package tlpw_pkg;

  localparam int STORE_WORDS = 8192;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W = ADDR_W - IDX_W;

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam logic REG_PAGING = 1'b0;
  localparam logic REG_DIR_PAGE = 1'b1;

  localparam logic [31:0] ACCESSED_MASK = 32'h0000_0020;
  localparam logic [31:0] DIRTY_MASK = 32'h0000_0040;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR_RD,
    ST_DIR_CHK,
    ST_TBL_CHK,
    ST_DIR_WB,
    ST_TBL_WB,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic       fault;
    logic [2:0] code;
  } check_t;

  // Present, writable and user checks on one entry; code is {user, write, protection}.
  function automatic check_t entry_check(logic [31:0] entry, logic wr, logic user);
    check_t r;
    r.fault = 1'b0;
    r.code = 3'd0;
    if (!entry[0]) begin
      r.fault = 1'b1;
      r.code = {user, wr, 1'b0};
    end else if (wr && !entry[1]) begin
      r.fault = 1'b1;
      r.code = {user, 1'b1, 1'b1};
    end else if (user && !entry[2]) begin
      r.fault = 1'b1;
      r.code = {1'b1, wr, 1'b1};
    end
    return r;
  endfunction

endpackage

// File: design/tlpw_store.sv
// Single-port table word store with registered read data.
module tlpw_store (
  input  logic              clk,
  input  tlpw_pkg::mem_req_t req,
  output logic [31:0]       rdata
);

  logic [31:0] mem [tlpw_pkg::STORE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// File: design/two_level_page_walker_unit.sv
// Top level of the two-level page walker: sequencer, config registers and stream ports.
// Translates 32-bit linear addresses through a two-level 4 KiB page table kept in an
// internal 8192-word store, or loads one store word (tuser mode 2). One item is worked
// at a time; s_tready is high only while the sequencer is idle. A full translation makes
// two dependent reads of the single store port, then the accessed/dirty writebacks of
// the directory and table entry through that same port. A fault at the directory or at
// the table ends the walk after that level's check; a load writes its word and then ends,
// and a pass-through (paging off) or an unused mode goes straight to the result. The result
// waits in an output register, and the sequencer holds its last step until that register
// is free; it is idle again from the edge that offers the result.
// The store holds no defined contents after reset: every word a walk reads must first be
// loaded. Config registers: paging_enable at 0x0, directory_page at 0x4; write them idle.
module two_level_page_walker_unit (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // linear_address[31:0], word_index[44:32], word_data[76:45]
  input  logic [2:0]  s_tuser,  // mode[1:0], user_mode[2]
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // physical_address[31:0], fault_code[34:32],
                                // fault_address[66:35]
  output logic        m_tuser,  // fault[0]
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlpw_pkg::state_t   state;
  tlpw_pkg::state_t   state_next;
  tlpw_pkg::mem_req_t mem_req;
  tlpw_pkg::check_t   chk;

  logic        paging_enable;
  logic [2:0]  directory_page;

  logic [1:0]  mode;
  logic        user_mode;
  logic [31:0] lin_addr;
  logic [tlpw_pkg::ADDR_W-1:0] word_index;
  logic [31:0] word_data;

  logic [31:0] dir_entry;
  logic [31:0] tbl_entry;
  logic [31:0] res_phys;
  logic        res_fault;
  logic [2:0]  res_code;
  logic [31:0] rdata;

  logic        is_write;
  logic        out_free;
  logic [tlpw_pkg::ADDR_W-1:0] dir_slot;
  logic [tlpw_pkg::ADDR_W-1:0] tbl_slot_rd;
  logic [tlpw_pkg::ADDR_W-1:0] tbl_slot_wb;

  assign is_write = (mode == tlpw_pkg::MODE_WRITE);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == tlpw_pkg::ST_IDLE);
  assign pready = 1'b1;

  // slots wrap modulo the store size: page bits above the store are dropped
  assign dir_slot = {tlpw_pkg::PAGE_W'(directory_page), lin_addr[31:22]};
  assign tbl_slot_rd = {tlpw_pkg::PAGE_W'(rdata[31:12]), lin_addr[21:12]};
  assign tbl_slot_wb = {tlpw_pkg::PAGE_W'(dir_entry[31:12]), lin_addr[21:12]};

  // one check unit serves both levels, since the store read data is the entry either way
  assign chk = tlpw_pkg::entry_check(rdata, is_write, user_mode);

  tlpw_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enable <= 1'b0;
      directory_page <= 3'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        tlpw_pkg::REG_PAGING:   paging_enable <= pwdata[0];
        tlpw_pkg::REG_DIR_PAGE: directory_page <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tlpw_pkg::REG_PAGING:   prdata = {31'd0, paging_enable};
      tlpw_pkg::REG_DIR_PAGE: prdata = {29'd0, directory_page};
      default:                prdata = 32'd0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tlpw_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[1:0] == tlpw_pkg::MODE_LOAD) begin
            state_next = tlpw_pkg::ST_LOAD;
          end else if (paging_enable && (s_tuser[1:0] == tlpw_pkg::MODE_READ ||
                                         s_tuser[1:0] == tlpw_pkg::MODE_WRITE)) begin
            state_next = tlpw_pkg::ST_DIR_RD;
          end else begin
            state_next = tlpw_pkg::ST_DONE;
          end
        end
      end
      tlpw_pkg::ST_DIR_RD:  state_next = tlpw_pkg::ST_DIR_CHK;
      tlpw_pkg::ST_DIR_CHK: state_next = chk.fault ? tlpw_pkg::ST_DONE : tlpw_pkg::ST_TBL_CHK;
      tlpw_pkg::ST_TBL_CHK: state_next = chk.fault ? tlpw_pkg::ST_DONE : tlpw_pkg::ST_DIR_WB;
      tlpw_pkg::ST_DIR_WB:  state_next = tlpw_pkg::ST_TBL_WB;
      tlpw_pkg::ST_TBL_WB:  state_next = tlpw_pkg::ST_DONE;
      tlpw_pkg::ST_LOAD:    state_next = tlpw_pkg::ST_DONE;
      tlpw_pkg::ST_DONE:    state_next = out_free ? tlpw_pkg::ST_IDLE : tlpw_pkg::ST_DONE;
      default:              state_next = tlpw_pkg::ST_IDLE;
    endcase
  end

  // store port requests
  always_comb begin
    mem_req.we = 1'b0;
    mem_req.addr = dir_slot;
    mem_req.wdata = dir_entry | tlpw_pkg::ACCESSED_MASK;
    case (state)
      tlpw_pkg::ST_DIR_RD: mem_req.addr = dir_slot;
      tlpw_pkg::ST_DIR_CHK: mem_req.addr = tbl_slot_rd;
      tlpw_pkg::ST_DIR_WB: begin
        mem_req.we = 1'b1;
        mem_req.addr = dir_slot;
        mem_req.wdata = dir_entry | tlpw_pkg::ACCESSED_MASK;
      end
      tlpw_pkg::ST_TBL_WB: begin
        // when both slots coincide, tbl_entry equals dir_entry and keeps the accessed bit
        mem_req.we = 1'b1;
        mem_req.addr = tbl_slot_wb;
        mem_req.wdata = tbl_entry | tlpw_pkg::ACCESSED_MASK |
                        (is_write ? tlpw_pkg::DIRTY_MASK : 32'd0);
      end
      tlpw_pkg::ST_LOAD: begin
        mem_req.we = 1'b1;
        mem_req.addr = word_index;
        mem_req.wdata = word_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpw_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tlpw_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      tlpw_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mode <= s_tuser[1:0];
          user_mode <= s_tuser[2];
          lin_addr <= s_tdata[31:0];
          word_index <= tlpw_pkg::ADDR_W'(s_tdata[44:32]);
          word_data <= s_tdata[76:45];
          res_fault <= 1'b0;
          res_code <= 3'd0;
          res_phys <= (!paging_enable && (s_tuser[1:0] == tlpw_pkg::MODE_READ ||
                                          s_tuser[1:0] == tlpw_pkg::MODE_WRITE))
                      ? s_tdata[31:0] : 32'd0;
        end
      end
      tlpw_pkg::ST_DIR_CHK: begin
        dir_entry <= rdata;
        res_fault <= chk.fault;
        res_code <= chk.code;
      end
      tlpw_pkg::ST_TBL_CHK: begin
        tbl_entry <= rdata;
        res_fault <= chk.fault;
        res_code <= chk.code;
        if (!chk.fault) begin
          res_phys <= {rdata[31:12], lin_addr[11:0]};
        end
      end
      tlpw_pkg::ST_DONE: begin
        if (out_free) begin
          m_tdata <= {5'd0, (res_fault ? lin_addr : 32'd0), res_code, res_phys};
          m_tuser <= res_fault;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_store_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == tlpw_pkg::ST_DIR_WB || state == tlpw_pkg::ST_TBL_WB ||
                    state == tlpw_pkg::ST_LOAD))
    else $error("store written outside a writeback or load step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is still in work");

  a_fault_no_phys: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
    else $error("faulting result carries a physical address");

  a_clean_no_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[34:32] == 3'd0 && m_tdata[66:35] == 32'd0))
    else $error("result without fault carries fault code or address");

  a_fault_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == tlpw_pkg::ST_DIR_CHK && chk.fault) |=> (state == tlpw_pkg::ST_DONE && res_fault))
    else $error("directory fault did not end the walk");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the two-level page walker: directed walks, then random loads and walks.
module tb_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL = 24;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [31:0]                 lin;
    logic                        usr;
    logic [tlpw_pkg::ADDR_W-1:0] widx;
    logic [31:0]                 wdata;
  } walk_req_t;

  typedef struct packed {
    logic [31:0] phys;
    logic        flt;
    logic [2:0]  code;
    logic [31:0] faddr;
  } walk_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;  // linear_address[31:0], word_index[44:32], word_data[76:45]
  logic [2:0]  s_tuser = '0;  // mode[1:0], user_mode[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;       // physical_address[31:0], fault_code[34:32], fault_address[66:35]
  logic        m_tuser;       // fault[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_level_page_walker_unit uut (.*);

  initial forever #5 clk = ~clk;

  // predictor state, updated at each input transfer
  logic [31:0]                 pt_mem [tlpw_pkg::STORE_WORDS];
  logic                        paging_on = 1'b0;
  logic [tlpw_pkg::PAGE_W-1:0] dir_page = '0;

  // plan-time view of the store, so walks only read words loaded earlier
  logic [31:0] plan_mem [tlpw_pkg::STORE_WORDS];
  bit          plan_known [tlpw_pkg::STORE_WORDS];
  logic [31:0] addr_pool [POOL];

  walk_req_t walk_reqs[$];
  walk_rsp_t due_results[$];

  walk_req_t drv_req, mon_req;
  walk_rsp_t mon_want, mon_got;
  int  tx_gap = 0, rx_hold = 0, cyc = 0;
  bit  quiet = 1'b0, calm = 1'b0;
  int  bad_cnt = 0, n_walks = 0, n_faults = 0, n_loads = 0, n_unused = 0, n_settings = 0;
  int  n_planned = 0;

  function automatic void note_bad(string what);
    if (bad_cnt < 10) $display("MISMATCH cycle %0d: %s", cyc, what);
    bad_cnt++;
  endfunction

  // {fault, code}; code is {user, write, protection}
  function automatic logic [3:0] perm_check(logic [31:0] e, logic wr, logic usr);
    if (!e[0]) return {1'b1, usr, wr, 1'b0};
    if (wr && !e[1]) return {1'b1, usr, 2'b11};
    if (usr && !e[2]) return {1'b1, 1'b1, wr, 1'b1};
    return 4'd0;
  endfunction

  function automatic walk_rsp_t walk_predict(walk_req_t r);
    walk_rsp_t                   o;
    logic                        wr;
    logic [3:0]                  chk;
    logic [tlpw_pkg::ADDR_W-1:0] dslot, tslot;
    logic [31:0]                 tent;
    o = '0;
    tent = '0;
    tslot = '0;
    wr = (r.mode == tlpw_pkg::MODE_WRITE);
    if (r.mode == tlpw_pkg::MODE_LOAD) begin
      pt_mem[r.widx] = r.wdata;
    end else if (r.mode == tlpw_pkg::MODE_READ || wr) begin
      if (!paging_on) begin
        o.phys = r.lin;
      end else begin
        dslot = {dir_page, r.lin[31:22]};
        chk = perm_check(pt_mem[dslot], wr, r.usr);
        if (!chk[3]) begin
          tslot = {pt_mem[dslot][12 +: tlpw_pkg::PAGE_W], r.lin[21:12]};
          tent = pt_mem[tslot];
          chk = perm_check(tent, wr, r.usr);
        end
        if (chk[3]) begin
          o.flt = 1'b1;
          o.code = chk[2:0];
          o.faddr = r.lin;
        end else begin
          o.phys = {tent[31:12], r.lin[11:0]};
          // directory first: a self-mapped entry collects both updates
          pt_mem[dslot] = pt_mem[dslot] | tlpw_pkg::ACCESSED_MASK;
          pt_mem[tslot] = pt_mem[tslot] | (wr ? (tlpw_pkg::ACCESSED_MASK |
                                                 tlpw_pkg::DIRTY_MASK)
                                              : tlpw_pkg::ACCESSED_MASK);
        end
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_entry();
    logic [31:0] e;
    e = $urandom;
    e[0] = ($urandom_range(0, 9) != 0);
    e[1] = ($urandom_range(0, 3) != 0);
    e[2] = ($urandom_range(0, 3) != 0);
    return e;
  endfunction

  task automatic plan_load(input logic [tlpw_pkg::ADDR_W-1:0] idx, input logic [31:0] data);
    walk_req_t r;
    r.mode = tlpw_pkg::MODE_LOAD;
    r.lin = $urandom;
    r.usr = 1'($urandom_range(0, 1));
    r.widx = idx;
    r.wdata = data;
    plan_mem[idx] = data;
    plan_known[idx] = 1'b1;
    walk_reqs.push_back(r);
    n_planned++;
  endtask

  // loads any missing entry on the walk path first
  task automatic plan_walk(input logic [1:0] mode, input logic [31:0] lin, input logic usr);
    walk_req_t                   r;
    logic [tlpw_pkg::ADDR_W-1:0] dslot, tslot;
    if (paging_on && mode != MODE_UNUSED) begin
      dslot = {dir_page, lin[31:22]};
      if (!plan_known[dslot]) plan_load(dslot, rand_entry());
      if (plan_mem[dslot][0]) begin
        tslot = {plan_mem[dslot][12 +: tlpw_pkg::PAGE_W], lin[21:12]};
        if (!plan_known[tslot]) plan_load(tslot, rand_entry());
      end
    end
    r.mode = mode;
    r.lin = lin;
    r.usr = usr;
    r.widx = tlpw_pkg::ADDR_W'($urandom);
    r.wdata = $urandom;
    walk_reqs.push_back(r);
    n_planned++;
  endtask

  // plans about n input items, counting the loads a walk pulls in
  task automatic plan_random(input int n);
    int                          pick, first;
    logic [31:0]                 lin;
    logic [tlpw_pkg::ADDR_W-1:0] dslot, slot;
    first = n_planned;
    while (n_planned - first < n) begin
      pick = $urandom_range(0, 99);
      lin = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, POOL - 1)] : $urandom;
      if (pick < 42) begin
        plan_walk(tlpw_pkg::MODE_READ, lin, 1'($urandom_range(0, 1)));
      end else if (pick < 82) begin
        plan_walk(tlpw_pkg::MODE_WRITE, lin, 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        plan_load(tlpw_pkg::ADDR_W'($urandom), $urandom);
      end else if (pick < 95) begin
        // rewrite an entry on a known walk path to change its permissions
        dslot = {dir_page, lin[31:22]};
        slot = dslot;
        if (plan_known[dslot] && plan_mem[dslot][0] && $urandom_range(0, 1))
          slot = {plan_mem[dslot][12 +: tlpw_pkg::PAGE_W], lin[21:12]};
        plan_load(slot, rand_entry());
      end else begin
        plan_walk(MODE_UNUSED, lin, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] val);
    logic [31:0] back;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == tlpw_pkg::REG_PAGING) paging_on = val[0];
    else dir_page = val[tlpw_pkg::PAGE_W-1:0];
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == tlpw_pkg::REG_PAGING ? (back[0] !== paging_on)
                                    : (back[tlpw_pkg::PAGE_W-1:0] !== dir_page))
      note_bad($sformatf("register %0d readback %h, wrote %h", idx, back, val));
    n_settings++;
  endtask

  // checked on the falling edge, after the driver's updates of this cycle have landed
  task automatic wait_idle();
    while (walk_reqs.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) quiet <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && !quiet && walk_reqs.size() != 0 && $urandom_range(0, 3) == 0) begin
        tx_gap <= $urandom_range(0, 11);
        s_tvalid <= 1'b0;
      end else if (walk_reqs.size() != 0) begin
        drv_req = walk_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, drv_req.wdata, drv_req.widx, drv_req.lin};
        s_tuser <= {drv_req.usr, drv_req.mode};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= (rx_hold == 1);
    end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      rx_hold <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        mon_got.phys = m_tdata[31:0];
        mon_got.flt = m_tuser;
        mon_got.code = m_tdata[34:32];
        mon_got.faddr = m_tdata[66:35];
        if (mon_got.flt) n_faults++;
        if (due_results.size() == 0) begin
          note_bad($sformatf("unexpected result phys %h fault %b code %0d faddr %h",
                             mon_got.phys, mon_got.flt, mon_got.code, mon_got.faddr));
        end else begin
          mon_want = due_results.pop_front();
          if (mon_got !== mon_want)
            note_bad($sformatf("exp/act phys %h/%h fault %b/%b code %0d/%0d faddr %h/%h",
                               mon_want.phys, mon_got.phys, mon_want.flt, mon_got.flt,
                               mon_want.code, mon_got.code, mon_want.faddr, mon_got.faddr));
        end
      end
      if (s_tvalid && s_tready) begin
        mon_req.lin = s_tdata[31:0];
        mon_req.widx = s_tdata[44:32];
        mon_req.wdata = s_tdata[76:45];
        mon_req.mode = s_tuser[1:0];
        mon_req.usr = s_tuser[2];
        case (mon_req.mode)
          tlpw_pkg::MODE_READ, tlpw_pkg::MODE_WRITE: n_walks++;
          tlpw_pkg::MODE_LOAD: n_loads++;
          default: n_unused++;
        endcase
        due_results.push_back(walk_predict(mon_req));
      end
    end
  end

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_seq
    int i;
    for (i = 0; i < POOL; i++) begin
      addr_pool[i] = $urandom;
      // groups of addresses share a directory entry
      if (i >= 4) addr_pool[i][31:22] = addr_pool[i % 4][31:22];
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // paging off: addresses pass straight through
    set_reg(tlpw_pkg::REG_PAGING, 32'd0);
    set_reg(tlpw_pkg::REG_DIR_PAGE, 32'd0);
    plan_walk(tlpw_pkg::MODE_READ, 32'h0000_0000, 1'b0);
    plan_walk(tlpw_pkg::MODE_WRITE, 32'hFFFF_FFFF, 1'b1);
    plan_walk(MODE_UNUSED, $urandom, 1'b1);
    plan_load(13'd0, 32'h0000_0000);
    plan_load(13'd8191, 32'hFFFF_FFFF);
    wait_idle();

    // directory in the top page; one case per fault kind
    set_reg(tlpw_pkg::REG_DIR_PAGE, 32'd7);
    set_reg(tlpw_pkg::REG_PAGING, 32'd1);
    plan_load(13'd7168, 32'h0000_1007);
    plan_load(13'd1024, 32'hFFFF_F007);
    plan_walk(tlpw_pkg::MODE_READ, 32'h0000_0ABC, 1'b1);
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0000_0FFF, 1'b0);
    plan_load(13'd7169, 32'h0000_1006);           // directory not present
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0040_0000, 1'b1);
    plan_load(13'd7170, 32'h0000_1005);           // directory read-only
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0080_0123, 1'b0);
    plan_walk(tlpw_pkg::MODE_READ, 32'h0080_0123, 1'b1);
    plan_load(13'd7171, 32'h0000_1003);           // directory supervisor-only
    plan_walk(tlpw_pkg::MODE_READ, 32'h00C0_0000, 1'b1);
    plan_load(13'd7172, 32'hFFFF_F007);           // table page wraps around the store
    plan_load(13'd7176, 32'h0000_0000);
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0100_8000, 1'b1);
    plan_load(13'd7173, 32'h0000_7007);           // entry is its own table entry
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0140_5123, 1'b1);
    plan_load(13'd1025, 32'h1234_5005);           // table read-only
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0000_1000, 1'b1);
    plan_load(13'd1026, 32'h0ABC_D003);           // table supervisor-only
    plan_walk(tlpw_pkg::MODE_READ, 32'h0000_2000, 1'b1);
    plan_walk(tlpw_pkg::MODE_WRITE, 32'h0000_2FFF, 1'b0);
    wait_idle();

    set_reg(tlpw_pkg::REG_DIR_PAGE, 32'd0);
    plan_random(110);
    wait_idle();
    set_reg(tlpw_pkg::REG_PAGING, 32'd0);
    set_reg(tlpw_pkg::REG_DIR_PAGE, 32'd3);
    plan_random(50);
    wait_idle();
    set_reg(tlpw_pkg::REG_PAGING, 32'd1);
    set_reg(tlpw_pkg::REG_DIR_PAGE, 32'd5);
    plan_random(110);
    wait_idle();
    set_reg(tlpw_pkg::REG_DIR_PAGE, $urandom_range(0, 7));
    calm = 1'b1;
    plan_random(110);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d translations (%0d faulted), %0d table loads, %0d unused-mode items,",
             n_walks, n_faults, n_loads, n_unused);
    $display("across %0d register writes with paging on and off and several directory pages.",
             n_settings);
    if (bad_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", bad_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
